// ===== hw/rtl/fss_pkg.sv =====
// shared types, codes and constants for the fat16 file sector sequencer
`default_nettype none
package fss_pkg;

    localparam int BLOCK_BYTES_DEF = 512;
    localparam int QUOT_W          = 17;
    localparam int RECIP_SHIFT     = 30;

    localparam logic [1:0] OP_OPEN  = 2'd0;
    localparam logic [1:0] OP_NEXT  = 2'd1;
    localparam logic [1:0] OP_REPLY = 2'd2;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_FAT   = 2'd1;
    localparam logic [1:0] KIND_EOF   = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_ENTRY  = 2'd1;
    localparam logic [1:0] STATUS_CHAIN_END  = 2'd2;
    localparam logic [1:0] STATUS_UNEXPECTED = 2'd3;

    localparam logic [1:0] REG_FAT_START       = 2'd0;
    localparam logic [1:0] REG_DATA_START      = 2'd1;
    localparam logic [1:0] REG_CLUSTER_SECTORS = 2'd2;

    localparam logic [15:0] CHAIN_END = 16'hFFF8;
    localparam logic [15:0] LAST_GOOD = 16'hFFEF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] start_cluster;
        logic [31:0] byte_length;
        logic [15:0] fat_value;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] sector_address;
        logic [9:0]  block_bytes;
        logic [7:0]  entry_slot;
        logic [1:0]  status;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [31:0] fat_start_sector;
        logic [31:0] data_start_sector;
        logic [7:0]  cluster_sectors;
    } cfg_t;

    // item with the fat sector and slot quotients of its cluster value
    typedef struct packed {
        in_t               item;
        logic [QUOT_W-1:0] fat_quot;
        logic [QUOT_W-1:0] slot_quot;
    } prep_t;

    typedef struct packed {
        logic [1:0] count;
        out_t       r0;
        out_t       r1;
    } step_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fss_engine.sv =====
// cluster chain state and per-transaction result computation
`default_nettype none
module fss_engine
    import fss_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  fire,
    input  wire prep_t prep,
    input  wire cfg_t  cfg,
    output step_t      step
);

    localparam int HALF_BYTES = BLOCK_BYTES / 2;

    logic [15:0]       cluster_reg, cluster_next;
    logic [QUOT_W-1:0] fat_quot_reg, fat_quot_next;
    logic [QUOT_W-1:0] slot_quot_reg, slot_quot_next;
    logic [7:0]        sector_reg, sector_next;
    logic [31:0]       remaining_reg, remaining_next;
    logic              awaiting_reg, awaiting_next;

    logic              is_open;
    logic [15:0]       cl;
    logic [QUOT_W-1:0] fq;
    logic [QUOT_W-1:0] sq;
    logic [7:0]        sec;
    logic [31:0]       rem;
    logic [7:0]        cs_eff;
    logic [31:0]       size;
    logic [31:0]       data_addr;
    logic [31:0]       fat_addr;
    logic [31:0]       slot_full;
    logic [7:0]        sec_inc;
    logic [31:0]       rem_dec;
    logic              crossing;
    logic              do_issue;
    logic              do_eof;
    logic              do_reply;
    logic [15:0]       fv;
    out_t              blank;

    always_comb
    begin
        is_open = (prep.item.opcode == OP_OPEN);
        cl      = is_open ? prep.item.start_cluster : cluster_reg;
        fq      = is_open ? prep.fat_quot : fat_quot_reg;
        sq      = is_open ? prep.slot_quot : slot_quot_reg;
        sec     = is_open ? 8'd0 : sector_reg;
        rem     = is_open ? prep.item.byte_length : remaining_reg;
        cs_eff  = (cfg.cluster_sectors == 8'd0) ? 8'd1 : cfg.cluster_sectors;
        fv      = prep.item.fat_value;

        size      = (rem >= 32'(BLOCK_BYTES)) ? 32'(BLOCK_BYTES) : rem;
        data_addr = cfg.data_start_sector + 32'((32'(cl) - 32'd2) * 32'(cs_eff))
                    + 32'(sec);
        fat_addr  = cfg.fat_start_sector + 32'(fq);
        slot_full = 32'(cl) - 32'(32'(sq) * 32'(HALF_BYTES));
        sec_inc   = sec + 8'd1;
        rem_dec   = rem - size;
        crossing  = (rem_dec != 32'd0) && (sec_inc >= cs_eff);

        do_issue = (rem != 32'd0)
                   && (is_open || (prep.item.opcode == OP_NEXT && !awaiting_reg));
        do_eof   = (rem == 32'd0)
                   && (is_open || (prep.item.opcode == OP_NEXT && !awaiting_reg));
        do_reply = (prep.item.opcode == OP_REPLY) && awaiting_reg;

        blank = '0;
        step  = '0;

        cluster_next   = cluster_reg;
        fat_quot_next  = fat_quot_reg;
        slot_quot_next = slot_quot_reg;
        sector_next    = sector_reg;
        remaining_next = remaining_reg;
        awaiting_next  = awaiting_reg;

        if (is_open)
        begin
            cluster_next   = cl;
            fat_quot_next  = fq;
            slot_quot_next = sq;
            sector_next    = 8'd0;
            remaining_next = rem;
            awaiting_next  = 1'b0;
        end

        if (do_issue)
        begin
            sector_next    = sec_inc;
            remaining_next = rem_dec;
            awaiting_next  = crossing;
            step.r0                = blank;
            step.r0.kind           = KIND_READ;
            step.r0.sector_address = data_addr;
            step.r0.block_bytes    = size[9:0];
            step.r0.last           = !crossing;
            step.r1                = blank;
            step.r1.kind           = KIND_FAT;
            step.r1.sector_address = fat_addr;
            step.r1.entry_slot     = slot_full[7:0];
            step.r1.last           = 1'b1;
            step.count             = crossing ? 2'd2 : 2'd1;
        end
        else if (do_eof)
        begin
            step.r0      = blank;
            step.r0.kind = KIND_EOF;
            step.r0.last = 1'b1;
            step.count   = 2'd1;
        end
        else if (do_reply)
        begin
            awaiting_next = 1'b0;
            if (fv >= CHAIN_END)
            begin
                remaining_next = 32'd0;
                step.r0        = blank;
                step.r0.kind   = KIND_ERROR;
                step.r0.status = STATUS_CHAIN_END;
                step.r0.last   = 1'b1;
                step.count     = 2'd1;
            end
            else if (fv > LAST_GOOD || fv < 16'd2)
            begin
                remaining_next = 32'd0;
                step.r0        = blank;
                step.r0.kind   = KIND_ERROR;
                step.r0.status = STATUS_BAD_ENTRY;
                step.r0.last   = 1'b1;
                step.count     = 2'd1;
            end
            else
            begin
                cluster_next   = fv;
                fat_quot_next  = prep.fat_quot;
                slot_quot_next = prep.slot_quot;
                sector_next    = 8'd0;
                step.count     = 2'd0;
            end
        end
        else if (!is_open)
        begin
            step.r0        = blank;
            step.r0.kind   = KIND_ERROR;
            step.r0.status = STATUS_UNEXPECTED;
            step.r0.last   = 1'b1;
            step.count     = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_reg   <= '0;
            fat_quot_reg  <= '0;
            slot_quot_reg <= '0;
            sector_reg    <= '0;
            remaining_reg <= '0;
            awaiting_reg  <= 1'b0;
        end
        else if (fire)
        begin
            cluster_reg   <= cluster_next;
            fat_quot_reg  <= fat_quot_next;
            slot_quot_reg <= slot_quot_next;
            sector_reg    <= sector_next;
            remaining_reg <= remaining_next;
            awaiting_reg  <= awaiting_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fat16_file_sector_sequencer_top.sv =====
// top level: config registers, input register, engine and result pair stage
// an accepted transaction is held in the input register, and its results in the result pair stage
// throughput: one transaction per cycle while out_stall is low; a read paired with a fat fetch holds the
//   single result port until both its results are taken, so the next transaction waits on the pair
// reset: asynchronous, clears chain state, config registers (cluster size to 1)
//   and all valid flags
`default_nettype none
module fat16_file_sector_sequencer_top
    import fss_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_t         in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_t             out_data,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int HALF_BYTES = BLOCK_BYTES / 2;
    localparam longint unsigned FAT_RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
    localparam longint unsigned SLOT_RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(HALF_BYTES) - 64'd1) / 64'(HALF_BYTES);

    cfg_t        cfg_reg, cfg_next;
    prep_t       prep_reg, prep_next;
    logic        in_full_reg, in_full_next;
    logic        pair_valid_reg, pair_valid_next;
    logic        half_reg, half_next;
    logic        two_reg, two_next;
    out_t        r0_reg, r0_next;
    out_t        r1_reg, r1_next;

    step_t       step;
    logic        accept;
    logic        fire;
    logic        pop;
    logic        done;
    logic [15:0] cand;
    logic [47:0] fat_prod;
    logic [47:0] slot_prod;

    fss_engine #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_engine (
        .clk  (clk),
        .rst_n(rst_n),
        .fire (fire),
        .prep (prep_reg),
        .cfg  (cfg_reg),
        .step (step)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_FAT_START:       cfg_next.fat_start_sector  = cfg_data;
                REG_DATA_START:      cfg_next.data_start_sector = cfg_data;
                REG_CLUSTER_SECTORS: cfg_next.cluster_sectors   = cfg_data[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid = pair_valid_reg;
        out_data  = half_reg ? r1_reg : r0_reg;
        pop       = pair_valid_reg && !out_stall;
        done      = pop && (!two_reg || half_reg);
        fire      = in_full_reg && (step.count == 2'd0 || !pair_valid_reg || done);
        in_stall  = in_full_reg && !fire;
        accept    = in_valid && !in_stall;

        // quotients of the cluster value by reciprocal multiply
        cand      = (in_data.opcode == OP_OPEN) ? in_data.start_cluster : in_data.fat_value;
        fat_prod  = 48'({cand, 1'b0}) * 48'(FAT_RECIP);
        slot_prod = 48'(cand) * 48'(SLOT_RECIP);

        prep_next           = prep_reg;
        in_full_next        = in_full_reg;
        if (fire)
        begin
            in_full_next = 1'b0;
        end
        if (accept)
        begin
            prep_next.item      = in_data;
            prep_next.fat_quot  = fat_prod[RECIP_SHIFT +: QUOT_W];
            prep_next.slot_quot = slot_prod[RECIP_SHIFT +: QUOT_W];
            in_full_next        = 1'b1;
        end

        pair_valid_next = pair_valid_reg;
        half_next       = half_reg;
        two_next        = two_reg;
        r0_next         = r0_reg;
        r1_next         = r1_reg;
        if (fire && step.count != 2'd0)
        begin
            pair_valid_next = 1'b1;
            half_next       = 1'b0;
            two_next        = (step.count == 2'd2);
            r0_next         = step.r0;
            r1_next         = step.r1;
        end
        else if (done)
        begin
            pair_valid_next = 1'b0;
            half_next       = 1'b0;
        end
        else if (pop)
        begin
            half_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fat_start_sector  <= '0;
            cfg_reg.data_start_sector <= '0;
            cfg_reg.cluster_sectors   <= 8'd1;
            in_full_reg               <= 1'b0;
            pair_valid_reg            <= 1'b0;
            half_reg                  <= 1'b0;
            two_reg                   <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            in_full_reg    <= in_full_next;
            pair_valid_reg <= pair_valid_next;
            half_reg       <= half_next;
            two_reg        <= two_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prep_reg <= prep_next;
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
    end

    // a paired transaction is always a data read followed by a fat fetch
    a_pair_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        (pair_valid_reg && two_reg) |-> (r0_reg.kind == KIND_READ && r1_reg.kind == KIND_FAT
                                         && !r0_reg.last && r1_reg.last))
        else $error("paired results malformed");

    // second half only shown for a pair still held
    a_half_pair: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> (pair_valid_reg && two_reg))
        else $error("second result without a pair");

    // a held result that is not replaced must stay in place while stalled
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("result changed while stalled");

    // the closing result of a transaction carries last
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (pair_valid_reg && (half_reg || !two_reg)) |-> out_data.last)
        else $error("closing result without last");

endmodule
`default_nettype wire
